/* sv/annexb_nal_unit_splitter_top_defines.svh */
// ----------------------------------------------------------------------------
// NAL unit splitter assertion macros
// Shared concurrent assertion forms used by the splitter's top level.
// ----------------------------------------------------------------------------
`ifndef ANNEXB_NAL_UNIT_SPLITTER_TOP_DEFINES_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define NALSPLIT_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that, when true, forces a consequence in the same cycle.
`define NALSPLIT_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A condition that, when true, forces a consequence in the next cycle.
`define NALSPLIT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/nalsplit_pkg.sv */
// ----------------------------------------------------------------------------
// NAL unit splitter package
// Types and constants shared by the scanner, the result queue and the top.
// ----------------------------------------------------------------------------
`default_nettype none

package nalsplit_pkg;

  localparam int TYPE_BITS = 5;
  localparam int FIELD_BITS = 24;
  localparam int MASK_BITS = 32;

  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [7:0] START_BYTE = 8'h01;
  localparam logic [TYPE_BITS-1:0] IDR_TYPE = 5'd5;
  localparam logic [MASK_BITS-1:0] SKIP_RESET = 32'h0000_0240;

  localparam logic [1:0] RUN_TWO = 2'd2;
  localparam logic [1:0] RUN_FULL = 2'd3;

  typedef struct packed {
    logic                  closed_by_end;
    logic                  is_keyframe;
    logic [FIELD_BITS-1:0] unit_size;
    logic [FIELD_BITS-1:0] unit_offset;
    logic [TYPE_BITS-1:0]  unit_type;
  } unit_record_t;

  typedef struct packed {
    logic inside_unit;
    logic header_pending;
    logic at_origin;
  } scan_status_t;

endpackage

`default_nettype wire

/* sv/nalsplit_scan.sv */
// ----------------------------------------------------------------------------
// NAL unit splitter scanner
// Holds the stream position and start code state, and closes units.
// ----------------------------------------------------------------------------
`default_nettype none

module nalsplit_scan #(
  parameter int POSITION_BITS = 24
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_wr_en,
  input  wire  [nalsplit_pkg::MASK_BITS-1:0]   cfg_wr_data,
  input  wire                                  byte_valid,
  input  wire  [7:0]                           data_byte,
  input  wire                                  last_byte,
  output logic                                 rec_valid,
  output nalsplit_pkg::unit_record_t           rec,
  output nalsplit_pkg::scan_status_t           status
);

  logic [nalsplit_pkg::MASK_BITS-1:0] skip_type_mask;
  logic [POSITION_BITS-1:0]           byte_position;
  logic [POSITION_BITS-1:0]           unit_start;
  logic [1:0]                         zero_run;
  logic                               inside_unit;
  logic                               header_pending;
  logic [nalsplit_pkg::TYPE_BITS-1:0] current_type;

  logic [POSITION_BITS-1:0]           unit_start_next;
  logic [1:0]                         zero_run_next;
  logic                               inside_unit_next;
  logic                               header_pending_next;
  logic [nalsplit_pkg::TYPE_BITS-1:0] current_type_next;

  logic                               code_here;
  logic [POSITION_BITS-1:0]           code_pos;
  logic [POSITION_BITS-1:0]           size;
  logic [nalsplit_pkg::TYPE_BITS-1:0] emit_type;
  logic                               close_unit;
  logic                               by_end;

  always_comb begin
    unit_start_next = unit_start;
    inside_unit_next = inside_unit;
    header_pending_next = header_pending;
    current_type_next = current_type;
    code_here = 1'b0;
    code_pos = byte_position - ((zero_run == nalsplit_pkg::RUN_FULL) ?
                                POSITION_BITS'(3) : POSITION_BITS'(2));
    close_unit = 1'b0;
    by_end = 1'b0;
    size = code_pos - unit_start;
    emit_type = current_type;

    if (header_pending) begin
      current_type_next = data_byte[nalsplit_pkg::TYPE_BITS-1:0];
      unit_start_next = byte_position;
      header_pending_next = 1'b0;
      inside_unit_next = 1'b1;
    end else if (data_byte == nalsplit_pkg::START_BYTE && zero_run >= nalsplit_pkg::RUN_TWO) begin
      code_here = 1'b1;
      close_unit = inside_unit;
      inside_unit_next = 1'b0;
      header_pending_next = 1'b1;
    end

    if (data_byte == nalsplit_pkg::ZERO_BYTE) begin
      zero_run_next = (zero_run == nalsplit_pkg::RUN_FULL) ? zero_run : zero_run + 2'd1;
    end else begin
      zero_run_next = 2'd0;
    end

    if (last_byte && !code_here && inside_unit_next) begin
      close_unit = 1'b1;
      by_end = 1'b1;
      size = byte_position + POSITION_BITS'(1) - unit_start_next;
      emit_type = current_type_next;
    end
  end

  always_comb begin
    rec.unit_type = emit_type;
    rec.unit_offset = nalsplit_pkg::FIELD_BITS'(by_end ? unit_start_next : unit_start);
    rec.unit_size = nalsplit_pkg::FIELD_BITS'(size);
    rec.is_keyframe = (emit_type == nalsplit_pkg::IDR_TYPE);
    rec.closed_by_end = by_end;
    rec_valid = byte_valid && close_unit && !skip_type_mask[emit_type];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_type_mask <= nalsplit_pkg::SKIP_RESET;
      byte_position <= '0;
      unit_start <= '0;
      zero_run <= 2'd0;
      inside_unit <= 1'b0;
      header_pending <= 1'b0;
      current_type <= '0;
    end else begin
      if (cfg_wr_en) begin
        skip_type_mask <= cfg_wr_data;
      end
      if (byte_valid) begin
        if (last_byte) begin
          byte_position <= '0;
          unit_start <= '0;
          zero_run <= 2'd0;
          inside_unit <= 1'b0;
          header_pending <= 1'b0;
          current_type <= '0;
        end else begin
          byte_position <= byte_position + POSITION_BITS'(1);
          unit_start <= unit_start_next;
          zero_run <= zero_run_next;
          inside_unit <= inside_unit_next;
          header_pending <= header_pending_next;
          current_type <= current_type_next;
        end
      end
    end
  end

  assign status.inside_unit = inside_unit;
  assign status.header_pending = header_pending;
  assign status.at_origin = (byte_position == '0);

endmodule

`default_nettype wire

/* sv/nalsplit_outq.sv */
// ----------------------------------------------------------------------------
// NAL unit splitter result queue
// Two-entry register queue that decouples the scanner from the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module nalsplit_outq (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          push,
  input  wire nalsplit_pkg::unit_record_t push_rec,
  output logic                         has_room,
  output logic                         out_valid,
  input  wire                          out_ready,
  output nalsplit_pkg::unit_record_t   out_rec
);

  nalsplit_pkg::unit_record_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign has_room = (count != 2'd2);
  assign out_rec = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/annexb_nal_unit_splitter_top.sv */
// ----------------------------------------------------------------------------
// Annex B NAL unit splitter
// Scans an H.264 Annex B stream; one record per NAL unit not in the skip mask.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock and accepts a new byte in every
// cycle while its two-entry result queue has room. A unit record is written
// into the queue in the cycle that the closing byte is taken, so it is offered
// on the result stream from the queue registers once any older record ahead of
// it has been taken; the position, zero run and unit state registers of the
// scanner set this one-byte-per-clock rate. The skip mask may be written only
// while no byte is in flight and the queue is empty.
`default_nettype none

`include "annexb_nal_unit_splitter_top_defines.svh"

module annexb_nal_unit_splitter_top #(
  parameter int POSITION_BITS = 24
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_wr_en,
  input  wire  [31:0] cfg_wr_data,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // data_byte[7:0]
  input  wire  [7:0]  s_axis_tdata,
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // unit_type[4:0], unit_offset[28:5], unit_size[52:29], closed_by_end[53]
  output logic [55:0] m_axis_tdata,
  // is_keyframe[0]
  output logic        m_axis_tuser
);

  logic                       byte_valid;
  logic                       rec_valid;
  nalsplit_pkg::unit_record_t rec;
  nalsplit_pkg::unit_record_t out_rec;
  nalsplit_pkg::scan_status_t status;

  assign byte_valid = s_axis_tvalid && s_axis_tready;

  nalsplit_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .byte_valid (byte_valid),
    .data_byte  (s_axis_tdata),
    .last_byte  (s_axis_tlast),
    .rec_valid  (rec_valid),
    .rec        (rec),
    .status     (status)
  );

  nalsplit_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (rec_valid),
    .push_rec (rec),
    .has_room (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_rec  (out_rec)
  );

  assign m_axis_tdata = {2'b00, out_rec.closed_by_end, out_rec.unit_size,
                         out_rec.unit_offset, out_rec.unit_type};
  assign m_axis_tuser = out_rec.is_keyframe;

  `NALSPLIT_ASSERT_ALWAYS(a_open_or_pending, !(status.inside_unit && status.header_pending),
    "unit open and header pending at once")
  `NALSPLIT_ASSERT_IMPLY(a_full_has_result, !s_axis_tready, m_axis_tvalid,
    "input stalled with no result waiting")
  `NALSPLIT_ASSERT_IMPLY(a_keyframe_type, m_axis_tvalid,
    m_axis_tuser == (m_axis_tdata[4:0] == nalsplit_pkg::IDR_TYPE),
    "keyframe flag does not match unit type")
  `NALSPLIT_ASSERT_NEXT(a_clear_after_last, byte_valid && s_axis_tlast,
    status.at_origin && !status.inside_unit && !status.header_pending,
    "scanner state not cleared after last byte")

endmodule

`default_nettype wire
